// ----- rtl/lrtm_pkg.sv -----
package lrtm_pkg;

   localparam int MODULUS     = 10007;
   localparam int INDEX_WIDTH = 32;
   localparam int FIELD_W     = 14;
   localparam int TERM_W      = 14;

   // residues fit MOD_W bits; operands also carry raw 14-bit coefficients
   localparam int MOD_W   = $clog2(MODULUS + 1);
   localparam int MOD_W1  = MOD_W + 1;
   localparam int OPND_W  = (MOD_W > FIELD_W) ? MOD_W : FIELD_W;
   localparam int PROD_W  = 2 * OPND_W;
   // four products summed before one reduction
   localparam int SUM_W   = PROD_W + 2;
   localparam int RECIP_W = SUM_W - MOD_W + 2;
   localparam int BIT_W   = $clog2(INDEX_WIDTH);

   typedef logic [MOD_W-1:0]       mod_type;
   typedef logic [MOD_W1-1:0]      mod_wide_type;
   typedef logic [FIELD_W-1:0]     field_type;
   typedef logic [TERM_W-1:0]      term_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [BIT_W-1:0]       bit_type;
   typedef logic [OPND_W-1:0]      opnd_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [SUM_W-1:0]       sum_type;
   typedef logic [RECIP_W-1:0]     recip_type;
   typedef logic [3:0]             elem_type;
   typedef logic [1:0]             kk_type;
   typedef logic [3:0]             pc_type;

   // floor(2^SUM_W / MODULUS): quotient estimate is exact or one low
   localparam recip_type    RECIP    = RECIP_W'((64'd1 << SUM_W) / 64'(MODULUS));
   localparam mod_type      MOD_VAL  = MOD_W'(MODULUS);
   localparam mod_wide_type MOD_WIDE = MOD_W1'(MODULUS);

   localparam elem_type ELEM_LAST   = 4'd15;
   localparam elem_type COEF_LAST   = 4'd2;
   localparam elem_type RESULT_ELEM = 4'd3;   // row 0, column 3
   localparam kk_type   K_LAST      = 2'd3;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_PUSH_COEF,
      ACT_ISSUE_SQ,
      ACT_ISSUE_MUL,
      ACT_SWAP,
      ACT_NEXT_BIT,
      ACT_READ_RESULT,
      ACT_RESPOND
   } act_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_NO_START,
      COND_SMALL,
      COND_MORE_COEF,
      COND_PIPE_BUSY,
      COND_IDENT,
      COND_BIT_CLEAR,
      COND_MORE_ISSUE,
      COND_MORE_BITS
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      logic     load;
      logic     push_coef;
      logic     issue_sq;
      logic     issue_mul;
      logic     read_result;
      logic     respond;
      logic     small_index;
      logic     bank;
      logic     ident;
      elem_type elem;
      kk_type   kk;
   } ctl_type;

   localparam pc_type PC_IDLE      = 4'd0;
   localparam pc_type PC_CHECK     = 4'd1;
   localparam pc_type PC_COEF      = 4'd2;
   localparam pc_type PC_COEF_WAIT = 4'd3;
   localparam pc_type PC_SQ_TEST   = 4'd4;
   localparam pc_type PC_SQ        = 4'd5;
   localparam pc_type PC_SQ_WAIT   = 4'd6;
   localparam pc_type PC_SQ_SWAP   = 4'd7;
   localparam pc_type PC_MUL_TEST  = 4'd8;
   localparam pc_type PC_MUL       = 4'd9;
   localparam pc_type PC_MUL_WAIT  = 4'd10;
   localparam pc_type PC_MUL_SWAP  = 4'd11;
   localparam pc_type PC_NEXT      = 4'd12;
   localparam pc_type PC_READ      = 4'd13;
   localparam pc_type PC_RESP      = 4'd14;

   // jump to target when the condition holds, else fall through
   function automatic ucode_type ucode_rom(pc_type pc);
      ucode_type w;
      unique case (pc)
         PC_IDLE:      w = '{ACT_LOAD,        COND_NO_START,   PC_IDLE};
         PC_CHECK:     w = '{ACT_NONE,        COND_SMALL,      PC_RESP};
         PC_COEF:      w = '{ACT_PUSH_COEF,   COND_MORE_COEF,  PC_COEF};
         PC_COEF_WAIT: w = '{ACT_NONE,        COND_PIPE_BUSY,  PC_COEF_WAIT};
         PC_SQ_TEST:   w = '{ACT_NONE,        COND_IDENT,      PC_MUL_TEST};
         PC_SQ:        w = '{ACT_ISSUE_SQ,    COND_MORE_ISSUE, PC_SQ};
         PC_SQ_WAIT:   w = '{ACT_NONE,        COND_PIPE_BUSY,  PC_SQ_WAIT};
         PC_SQ_SWAP:   w = '{ACT_SWAP,        COND_ALWAYS,     PC_MUL_TEST};
         PC_MUL_TEST:  w = '{ACT_NONE,        COND_BIT_CLEAR,  PC_NEXT};
         PC_MUL:       w = '{ACT_ISSUE_MUL,   COND_MORE_ISSUE, PC_MUL};
         PC_MUL_WAIT:  w = '{ACT_NONE,        COND_PIPE_BUSY,  PC_MUL_WAIT};
         PC_MUL_SWAP:  w = '{ACT_SWAP,        COND_ALWAYS,     PC_NEXT};
         PC_NEXT:      w = '{ACT_NEXT_BIT,    COND_MORE_BITS,  PC_SQ_TEST};
         PC_READ:      w = '{ACT_READ_RESULT, COND_ALWAYS,     PC_RESP};
         PC_RESP:      w = '{ACT_RESPOND,     COND_ALWAYS,     PC_IDLE};
         default:      w = '{ACT_NONE,        COND_ALWAYS,     PC_IDLE};
      endcase
      return w;
   endfunction

   function automatic term_type to_term(mod_type v);
      logic [MOD_W+TERM_W-1:0] wide;
      wide = {{TERM_W{1'b0}}, v};
      return wide[TERM_W-1:0];
   endfunction

endpackage

// ----- rtl/linear_recurrence_term_mod_unit.sv -----
// for n <= 2 the result beat follows the accepted start beat with no matrix work;
// otherwise one squaring per bit below the top set bit of n-2, one multiply per set bit
// each 4x4 modular product runs as 64 multiply-accumulate steps on the one shared
// unit, then a pipeline drain and one bank swap; one item is in flight at a time
// the result strobe lasts one cycle and start is taken again in that same cycle
// reset is synchronous, active high, and returns the sequencer to idle
module linear_recurrence_term_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lrtm_pkg::index_type req_term_index,
   input  lrtm_pkg::field_type req_coef_prev1,
   input  lrtm_pkg::field_type req_coef_prev3,
   input  lrtm_pkg::field_type req_addend,
   output logic                rsp_valid,
   output lrtm_pkg::term_type  rsp_term_value
);

   lrtm_pkg::ctl_type  ctl;
   logic               pipe_busy;
   lrtm_pkg::mod_type  result;

   logic               rsp_valid_ff, rsp_valid_in;
   lrtm_pkg::term_type rsp_term_value_ff, rsp_term_value_in;

   lrtm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_term_index (req_term_index),
      .pipe_busy      (pipe_busy),
      .busy           (busy),
      .ctl            (ctl)
   );

   lrtm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_coef_prev1 (req_coef_prev1),
      .req_coef_prev3 (req_coef_prev3),
      .req_addend     (req_addend),
      .pipe_busy      (pipe_busy),
      .result         (result)
   );

   // index 0..2 answers zero without touching the matrix
   assign rsp_valid_in      = ctl.respond;
   assign rsp_term_value_in = ctl.small_index ? '0 : lrtm_pkg::to_term(result);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_term_value_ff <= rsp_term_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_value = rsp_term_value_ff;

endmodule

// ----- rtl/lrtm_seq.sv -----
module lrtm_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lrtm_pkg::index_type  req_term_index,
   input  logic                 pipe_busy,
   output logic                 busy,
   output lrtm_pkg::ctl_type    ctl
);

   lrtm_pkg::ucode_type word;
   logic                take;

   lrtm_pkg::pc_type    pc_ff, pc_in;
   lrtm_pkg::elem_type  elem_ff, elem_in;
   lrtm_pkg::kk_type    kk_ff, kk_in;
   lrtm_pkg::bit_type   bit_ff, bit_in;
   lrtm_pkg::index_type ex_ff, ex_in;
   logic                small_ff, small_in;
   logic                bank_ff, bank_in;
   logic                ident_ff, ident_in;

   assign word = lrtm_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (word.cond)
         lrtm_pkg::COND_ALWAYS:     take = 1'b1;
         lrtm_pkg::COND_NO_START:   take = !start;
         lrtm_pkg::COND_SMALL:      take = small_ff;
         lrtm_pkg::COND_MORE_COEF:  take = (elem_ff != lrtm_pkg::COEF_LAST);
         lrtm_pkg::COND_PIPE_BUSY:  take = pipe_busy;
         lrtm_pkg::COND_IDENT:      take = ident_ff;
         lrtm_pkg::COND_BIT_CLEAR:  take = !ex_ff[bit_ff];
         lrtm_pkg::COND_MORE_ISSUE: take = !((elem_ff == lrtm_pkg::ELEM_LAST) &&
                                             (kk_ff == lrtm_pkg::K_LAST));
         lrtm_pkg::COND_MORE_BITS:  take = (bit_ff != '0);
         default:                   take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in    = take ? word.target : pc_ff + 4'd1;
      elem_in  = elem_ff;
      kk_in    = kk_ff;
      bit_in   = bit_ff;
      ex_in    = ex_ff;
      small_in = small_ff;
      bank_in  = bank_ff;
      ident_in = ident_ff;
      unique case (word.act)
         lrtm_pkg::ACT_LOAD: begin
            if (start) begin
               ex_in    = req_term_index - lrtm_pkg::index_type'(2);
               small_in = (req_term_index < lrtm_pkg::index_type'(3));
               bit_in   = lrtm_pkg::bit_type'(lrtm_pkg::INDEX_WIDTH - 1);
               elem_in  = '0;
               kk_in    = '0;
               bank_in  = 1'b0;
               ident_in = 1'b1;
            end
         end
         lrtm_pkg::ACT_PUSH_COEF: begin
            elem_in = (elem_ff == lrtm_pkg::COEF_LAST) ? '0 : elem_ff + 4'd1;
         end
         lrtm_pkg::ACT_ISSUE_SQ, lrtm_pkg::ACT_ISSUE_MUL: begin
            {elem_in, kk_in} = {elem_ff, kk_ff} + 6'd1;
         end
         lrtm_pkg::ACT_SWAP: begin
            // result bank becomes the source; accumulator is no longer identity
            bank_in  = !bank_ff;
            ident_in = 1'b0;
         end
         lrtm_pkg::ACT_NEXT_BIT: begin
            if (bit_ff != '0) begin
               bit_in = bit_ff - lrtm_pkg::bit_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= lrtm_pkg::PC_IDLE;
         bank_ff  <= 1'b0;
         ident_ff <= 1'b1;
         small_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         bank_ff  <= bank_in;
         ident_ff <= ident_in;
         small_ff <= small_in;
      end
      elem_ff <= elem_in;
      kk_ff   <= kk_in;
      bit_ff  <= bit_in;
      ex_ff   <= ex_in;
   end

   assign busy = (pc_ff != lrtm_pkg::PC_IDLE);

   always_comb begin
      ctl.load        = (word.act == lrtm_pkg::ACT_LOAD) && start;
      ctl.push_coef   = (word.act == lrtm_pkg::ACT_PUSH_COEF);
      ctl.issue_sq    = (word.act == lrtm_pkg::ACT_ISSUE_SQ);
      ctl.issue_mul   = (word.act == lrtm_pkg::ACT_ISSUE_MUL);
      ctl.read_result = (word.act == lrtm_pkg::ACT_READ_RESULT);
      ctl.respond     = (word.act == lrtm_pkg::ACT_RESPOND);
      ctl.small_index = small_ff;
      ctl.bank        = bank_ff;
      ctl.ident       = ident_ff;
      ctl.elem        = elem_ff;
      ctl.kk          = kk_ff;
   end

endmodule

// ----- rtl/lrtm_dp.sv -----
module lrtm_dp (
   input  logic                clock,
   input  logic                reset,
   input  lrtm_pkg::ctl_type   ctl,
   input  lrtm_pkg::field_type req_coef_prev1,
   input  lrtm_pkg::field_type req_coef_prev3,
   input  lrtm_pkg::field_type req_addend,
   output logic                pipe_busy,
   output lrtm_pkg::mod_type   result
);

   typedef enum logic [1:0] {
      MODE_SQ,
      MODE_MUL,
      MODE_COEF
   } mode_type;

   typedef struct packed {
      logic               valid;
      mode_type           mode;
      logic               first;
      logic               last;
      lrtm_pkg::elem_type elem;
      lrtm_pkg::kk_type   kk;
   } tag_type;

   typedef struct packed {
      logic               valid;
      logic               to_coef;
      lrtm_pkg::elem_type elem;
   } dest_type;

   localparam int SCALE_W = lrtm_pkg::SUM_W + lrtm_pkg::RECIP_W;
   localparam int QM_W    = lrtm_pkg::RECIP_W + lrtm_pkg::MOD_W;

   // two banks of 4x4: one read as the source, the other takes the product
   lrtm_pkg::mod_type   acc_mem [32];
   logic [4:0]          raddr_x, raddr_y, waddr;
   logic                mem_we;

   lrtm_pkg::field_type coef_raw_ff [3];
   lrtm_pkg::mod_type   coef_ff [3];

   tag_type             tag_in, tag1_ff, tag2_ff;
   lrtm_pkg::mod_type   rdx_ff, rdy_ff;
   lrtm_pkg::mod_type   comp_val;
   lrtm_pkg::opnd_type  opx, opy;
   lrtm_pkg::prod_type  prod_ff;
   lrtm_pkg::sum_type   sum_ff;
   dest_type            dest3_ff, dest4_ff, dest5_ff;
   logic [SCALE_W-1:0]  scaled;
   lrtm_pkg::recip_type q_ff;
   lrtm_pkg::sum_type   sum4_ff, sum5_ff;
   logic [QM_W-1:0]     qm_full;
   lrtm_pkg::sum_type   qm_ff;
   lrtm_pkg::sum_type   diff;
   lrtm_pkg::mod_wide_type rem0, rem1;
   lrtm_pkg::mod_type   red_value;
   logic [1:0]          i1, j1, k1;

   always_comb begin
      tag_in.valid = ctl.issue_sq || ctl.issue_mul || ctl.push_coef;
      tag_in.mode  = ctl.push_coef ? MODE_COEF : (ctl.issue_mul ? MODE_MUL : MODE_SQ);
      tag_in.first = ctl.push_coef || (ctl.kk == '0);
      tag_in.last  = ctl.push_coef || (ctl.kk == lrtm_pkg::K_LAST);
      tag_in.elem  = ctl.elem;
      tag_in.kk    = ctl.kk;
   end

   assign raddr_x = ctl.read_result ? {ctl.bank, lrtm_pkg::RESULT_ELEM}
                                    : {ctl.bank, ctl.elem[3:2], ctl.kk};
   assign raddr_y = {ctl.bank, ctl.kk, ctl.elem[1:0]};
   assign waddr   = {!ctl.bank, dest5_ff.elem};
   assign mem_we  = dest5_ff.valid && !dest5_ff.to_coef;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[waddr] <= red_value;
      end
      rdx_ff <= acc_mem[raddr_x];
      rdy_ff <= acc_mem[raddr_y];
   end

   // operand select after the registered read
   assign i1 = tag1_ff.elem[3:2];
   assign j1 = tag1_ff.elem[1:0];
   assign k1 = tag1_ff.kk;

   // companion matrix entry at row k1, column j1
   always_comb begin
      unique case ({k1, j1})
         4'b00_00: comp_val = coef_ff[0];
         4'b00_10: comp_val = coef_ff[1];
         4'b00_11: comp_val = coef_ff[2];
         4'b01_00, 4'b10_01, 4'b11_11: comp_val = lrtm_pkg::mod_type'(1);
         default:  comp_val = '0;
      endcase
   end

   always_comb begin
      unique case (tag1_ff.mode)
         MODE_COEF: begin
            opx = lrtm_pkg::opnd_type'(coef_raw_ff[j1]);
            opy = lrtm_pkg::opnd_type'(1);
         end
         MODE_MUL: begin
            if (ctl.ident) begin
               opx = (i1 == k1) ? lrtm_pkg::opnd_type'(1) : '0;
            end else begin
               opx = lrtm_pkg::opnd_type'(rdx_ff);
            end
            opy = lrtm_pkg::opnd_type'(comp_val);
         end
         default: begin
            opx = lrtm_pkg::opnd_type'(rdx_ff);
            opy = lrtm_pkg::opnd_type'(rdy_ff);
         end
      endcase
   end

   // barrett style reduction: estimate quotient, then one correction
   assign scaled    = SCALE_W'(sum_ff) * SCALE_W'(lrtm_pkg::RECIP);
   assign qm_full   = QM_W'(q_ff) * QM_W'(lrtm_pkg::MOD_VAL);
   assign diff      = sum5_ff - qm_ff;
   assign rem0      = diff[lrtm_pkg::MOD_W:0];
   assign rem1      = (rem0 >= lrtm_pkg::MOD_WIDE) ? rem0 - lrtm_pkg::MOD_WIDE : rem0;
   assign red_value = rem1[lrtm_pkg::MOD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid  <= 1'b0;
         tag2_ff.valid  <= 1'b0;
         dest3_ff.valid <= 1'b0;
         dest4_ff.valid <= 1'b0;
         dest5_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid  <= tag_in.valid;
         tag2_ff.valid  <= tag1_ff.valid;
         dest3_ff.valid <= tag2_ff.valid && tag2_ff.last;
         dest4_ff.valid <= dest3_ff.valid;
         dest5_ff.valid <= dest4_ff.valid;
      end
      tag1_ff.mode  <= tag_in.mode;
      tag1_ff.first <= tag_in.first;
      tag1_ff.last  <= tag_in.last;
      tag1_ff.elem  <= tag_in.elem;
      tag1_ff.kk    <= tag_in.kk;

      tag2_ff.mode  <= tag1_ff.mode;
      tag2_ff.first <= tag1_ff.first;
      tag2_ff.last  <= tag1_ff.last;
      tag2_ff.elem  <= tag1_ff.elem;
      tag2_ff.kk    <= tag1_ff.kk;
      prod_ff       <= lrtm_pkg::prod_type'(opx) * lrtm_pkg::prod_type'(opy);

      if (tag2_ff.valid) begin
         sum_ff <= tag2_ff.first ? lrtm_pkg::sum_type'(prod_ff)
                                 : sum_ff + lrtm_pkg::sum_type'(prod_ff);
      end
      dest3_ff.to_coef <= (tag2_ff.mode == MODE_COEF);
      dest3_ff.elem    <= tag2_ff.elem;

      q_ff             <= scaled[SCALE_W-1:lrtm_pkg::SUM_W];
      sum4_ff          <= sum_ff;
      dest4_ff.to_coef <= dest3_ff.to_coef;
      dest4_ff.elem    <= dest3_ff.elem;

      qm_ff            <= qm_full[lrtm_pkg::SUM_W-1:0];
      sum5_ff          <= sum4_ff;
      dest5_ff.to_coef <= dest4_ff.to_coef;
      dest5_ff.elem    <= dest4_ff.elem;

      if (dest5_ff.valid && dest5_ff.to_coef) begin
         coef_ff[dest5_ff.elem[1:0]] <= red_value;
      end
      if (ctl.load) begin
         coef_raw_ff[0] <= req_coef_prev1;
         coef_raw_ff[1] <= req_coef_prev3;
         coef_raw_ff[2] <= req_addend;
      end
   end

   assign pipe_busy = tag1_ff.valid || tag2_ff.valid || dest3_ff.valid ||
                      dest4_ff.valid || dest5_ff.valid;
   assign result    = rdx_ff;

endmodule

// ----- rtl/lrtm_checker.sv -----
module lrtm_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input lrtm_pkg::term_type  rsp_term_value
);

   // one result beat per item, never two in a row
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted start did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer still busy");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_term_value < lrtm_pkg::MODULUS))
      else $error("result not reduced");

endmodule

bind linear_recurrence_term_mod_unit lrtm_checker u_lrtm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_term_value (rsp_term_value)
);

// ----- bench/linear_recurrence_term_mod_unit_tb.sv -----
`timescale 1ns / 100ps

module linear_recurrence_term_mod_unit_tb;

   typedef struct packed {
      lrtm_pkg::index_type n;
      lrtm_pkg::term_type  value;
   } term_expect_type;

   typedef struct packed {
      lrtm_pkg::index_type n;
      lrtm_pkg::field_type a;
      lrtm_pkg::field_type b;
      lrtm_pkg::field_type c;
      logic                known;
      lrtm_pkg::term_type  value;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 248;

   // rows with known set carry a value read straight off the recurrence
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{32'd0,          14'd16383, 14'd16383, 14'd16383, 1'b1, 14'd0},
      '{32'd1,          14'd0,     14'd0,     14'd0,     1'b1, 14'd0},
      '{32'd2,          14'd10006, 14'd10006, 14'd10006, 1'b1, 14'd0},
      '{32'd3,          14'd0,     14'd0,     14'd0,     1'b1, 14'd0},
      '{32'd3,          14'd16383, 14'd16383, 14'd10006, 1'b1, 14'd10006},
      '{32'd3,          14'd0,     14'd0,     14'd10007, 1'b1, 14'd0},
      '{32'd3,          14'd0,     14'd0,     14'd16383, 1'b1, 14'd6376},
      '{32'd4,          14'd0,     14'd0,     14'd5,     1'b1, 14'd5},
      '{32'd4,          14'd1,     14'd0,     14'd5,     1'b1, 14'd10},
      '{32'd4,          14'd10006, 14'd10006, 14'd10006, 1'b1, 14'd0},
      '{32'd6,          14'd1,     14'd0,     14'd1,     1'b1, 14'd4},
      '{32'd10,         14'd10007, 14'd10007, 14'd10007, 1'b1, 14'd0},
      '{32'd100,        14'd0,     14'd0,     14'd1,     1'b1, 14'd1},
      '{32'hFFFF_FFFF,  14'd0,     14'd0,     14'd7,     1'b1, 14'd7},
      '{32'd5,          14'd1,     14'd1,     14'd1,     1'b0, 14'd0},
      '{32'd10,         14'd2,     14'd3,     14'd1,     1'b0, 14'd0},
      '{32'd1000,       14'd10006, 14'd1,     14'd10006, 1'b0, 14'd0},
      '{32'hFFFF_FFFF,  14'd16383, 14'd16383, 14'd16383, 1'b0, 14'd0},
      '{32'h8000_0000,  14'd10006, 14'd10006, 14'd10006, 1'b0, 14'd0},
      '{32'h7FFF_FFFF,  14'd16383, 14'd0,     14'd1,     1'b0, 14'd0},
      '{32'h5555_5555,  14'd12345, 14'd6789,  14'd101,   1'b0, 14'd0},
      '{32'hAAAA_AAAA,  14'd3,     14'd16000, 14'd9999,  1'b0, 14'd0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   lrtm_pkg::index_type req_term_index = '0;
   lrtm_pkg::field_type req_coef_prev1 = '0;
   lrtm_pkg::field_type req_coef_prev3 = '0;
   lrtm_pkg::field_type req_addend     = '0;
   logic                rsp_valid;
   lrtm_pkg::term_type  rsp_term_value;

   term_expect_type pending_terms[$];
   int              error_count   = 0;
   int              items_sent    = 0;
   int              terms_checked = 0;
   int              wide_items    = 0;
   int              burst_left    = 1;

   linear_recurrence_term_mod_unit uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_term_index (req_term_index),
      .req_coef_prev1 (req_coef_prev1),
      .req_coef_prev3 (req_coef_prev3),
      .req_addend     (req_addend),
      .rsp_valid      (rsp_valid),
      .rsp_term_value (rsp_term_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // f(n) mod MODULUS by squaring the companion matrix, msb first
   function automatic lrtm_pkg::term_type recurrence_term(lrtm_pkg::index_type n,
                                                          lrtm_pkg::field_type a_raw,
                                                          lrtm_pkg::field_type b_raw,
                                                          lrtm_pkg::field_type c_raw);
      longint unsigned a, b, c, ex, sum, rhs;
      longint unsigned comp [4][4];
      longint unsigned pw   [4][4];
      longint unsigned prod [4][4];
      int              bit_i, pass, i, j, k;
      a  = longint'(a_raw) % lrtm_pkg::MODULUS;
      b  = longint'(b_raw) % lrtm_pkg::MODULUS;
      c  = longint'(c_raw) % lrtm_pkg::MODULUS;
      if (n <= 2)
         return '0;
      if (n == 3)
         return lrtm_pkg::term_type'(c);
      ex = longint'(n) - 2;
      for (i = 0; i < 4; i++) begin
         for (j = 0; j < 4; j++) begin
            comp[i][j] = 0;
            pw[i][j]   = (i == j) ? 1 : 0;
         end
      end
      comp[0][0] = a;
      comp[0][2] = b;
      comp[0][3] = c;
      comp[1][0] = 1;
      comp[2][1] = 1;
      comp[3][3] = 1;
      for (bit_i = lrtm_pkg::INDEX_WIDTH - 1; bit_i >= 0; bit_i--) begin
         // pass 0 squares, pass 1 multiplies in the companion when the bit is set
         for (pass = 0; pass < 2; pass++) begin
            if (pass == 0 || ((ex >> bit_i) & 1) != 0) begin
               for (i = 0; i < 4; i++) begin
                  for (j = 0; j < 4; j++) begin
                     sum = 0;
                     for (k = 0; k < 4; k++) begin
                        rhs = (pass == 0) ? pw[k][j] : comp[k][j];
                        sum += (pw[i][k] * rhs) % lrtm_pkg::MODULUS;
                     end
                     prod[i][j] = sum % lrtm_pkg::MODULUS;
                  end
               end
               for (i = 0; i < 4; i++)
                  for (j = 0; j < 4; j++)
                     pw[i][j] = prod[i][j];
            end
         end
      end
      return lrtm_pkg::term_type'(pw[0][3]);
   endfunction

   function automatic lrtm_pkg::field_type pick_coef();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         return lrtm_pkg::field_type'($urandom_range(0, lrtm_pkg::MODULUS - 1));
      if (sel < 90)
         return lrtm_pkg::field_type'($urandom_range(0, 16383));
      case ($urandom_range(0, 4))
         0:       return lrtm_pkg::field_type'(0);
         1:       return lrtm_pkg::field_type'(1);
         2:       return lrtm_pkg::field_type'(lrtm_pkg::MODULUS - 1);
         3:       return lrtm_pkg::field_type'(lrtm_pkg::MODULUS);
         default: return lrtm_pkg::field_type'(16383);
      endcase
   endfunction

   // one start beat, held until taken, then the sender's burst pacing
   task automatic issue_item(input lrtm_pkg::index_type n, input lrtm_pkg::field_type a,
                             input lrtm_pkg::field_type b, input lrtm_pkg::field_type c,
                             input logic known, input lrtm_pkg::term_type value);
      term_expect_type entry;
      int              gap;
      start          <= 1'b1;
      req_term_index <= n;
      req_coef_prev1 <= a;
      req_coef_prev3 <= b;
      req_addend     <= c;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      entry.n     = n;
      entry.value = known ? value : recurrence_term(n, a, b, c);
      pending_terms.push_back(entry);
      items_sent++;
      if (n >= 32'h0001_0000)
         wide_items++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 2000)
                                            : $urandom_range(1, 40);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_terms();
      start <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      term_expect_type entry;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_terms.size() == 0) begin
            $display("%t unexpected result: expected none, actual term_value=%0d",
                     $time, rsp_term_value);
            error_count++;
         end else begin
            entry = pending_terms.pop_front();
            terms_checked++;
            if (rsp_term_value !== entry.value) begin
               $display("%t term_value mismatch for n=%0d: expected %0d, actual %0d",
                        $time, entry.n, entry.value, rsp_term_value);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      lrtm_pkg::index_type n;
      int                  sel;
      int                  span;
      int                  idx;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < DIRECTED_COUNT; idx++)
         issue_item(directed_rows[idx].n, directed_rows[idx].a, directed_rows[idx].b,
                    directed_rows[idx].c, directed_rows[idx].known,
                    directed_rows[idx].value);
      drain_terms();

      // mostly short indexes to keep the run short, a fifth full width
      for (idx = 0; idx < RANDOM_COUNT; idx++) begin
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            n = $urandom_range(0, 6);
         end else if (sel < 80) begin
            span = 1 << $urandom_range(3, 12);
            n = $urandom_range(0, span - 1);
         end else begin
            n = $urandom;
         end
         issue_item(n, pick_coef(), pick_coef(), pick_coef(), 1'b0, '0);
         if (idx == RANDOM_COUNT / 2)
            drain_terms();
      end

      drain_terms();
      repeat (4800) @(posedge clock);

      $display("%0d items sent (%0d directed, %0d with index above 16 bits)",
               items_sent, DIRECTED_COUNT, wide_items);
      $display("%0d terms checked, %0d mismatches", terms_checked, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lrtm_pkg.sv
rtl/lrtm_seq.sv
rtl/lrtm_dp.sv
rtl/linear_recurrence_term_mod_unit.sv
rtl/lrtm_checker.sv
bench/linear_recurrence_term_mod_unit_tb.sv
